[rtl/core/lamp_mode_controller_unit_assert.svh]
// ----------------------------------------------------------------------------
// Lamp mode controller assertion macros
// Concurrent assertion wrappers shared by the lamp mode controller RTL.
// ----------------------------------------------------------------------------
`ifndef LAMP_MODE_CONTROLLER_UNIT_ASSERT_SVH
`define LAMP_MODE_CONTROLLER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked while out of reset.
`define LMC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Checked on every edge, reset included.
`define LMC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LMC_ASSERT(lbl, clk, rstn, prop, msg)
`define LMC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/core/lmc_pkg.sv]
// ----------------------------------------------------------------------------
// Lamp mode controller package
// Types, register indexes and reset constants shared by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lmc_pkg;

  // Operating modes, stepped in this order by the mode button.
  typedef enum logic [1:0] {
    MODE_AMBIENT = 2'd0,
    MODE_MANUAL  = 2'd1,
    MODE_DELAY   = 2'd2,
    MODE_DIMMER  = 2'd3
  } mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_DEBOUNCE_INTERVAL = 3'd0,
    REG_DEBOUNCE_CONFIRM  = 3'd1,
    REG_OFF_DELAY         = 3'd2,
    REG_LEVEL_ONE         = 3'd3,
    REG_LEVEL_TWO         = 3'd4,
    REG_LEVEL_THREE       = 3'd5,
    REG_LEVEL_FOUR        = 3'd6
  } reg_idx_e;

  localparam int unsigned CfgIdxWidth  = 3;
  localparam int unsigned CfgDataWidth = 16;
  localparam int unsigned NumLevels    = 4;

  localparam logic [7:0]  RstInterval = 8'd15;
  localparam logic [2:0]  RstConfirm  = 3'd3;
  localparam logic [15:0] RstOffDelay = 16'd10000;
  localparam logic [15:0] RstLevelOne   = 16'd1000;
  localparam logic [15:0] RstLevelTwo   = 16'd2500;
  localparam logic [15:0] RstLevelThree = 16'd5000;
  localparam logic [15:0] RstLevelFour  = 16'd10000;

  // Highest dimmer step; the step wraps to zero after it.
  localparam logic [2:0] TopStep = 3'd4;
  localparam logic [7:0] IntervalMax = 8'd255;

  typedef struct packed {
    logic [7:0] interval;
    logic [2:0] confirm;
  } db_cfg_t;

  typedef struct packed {
    db_cfg_t                          db;
    logic [15:0]                      off_delay;
    logic [NumLevels-1:0][15:0]       level;
  } cfg_t;

  typedef struct packed {
    logic       mode_press;
    logic       mode_pin;
    logic       action_press;
    logic       action_pin;
    logic [7:0] ambient_sample;
    logic [7:0] reference_sample;
  } in_t;

  typedef struct packed {
    logic        lamp_on;
    logic [15:0] pwm_compare;
    logic [1:0]  current_mode;
  } out_t;

endpackage

`default_nettype wire

[rtl/core/lmc_stream_if.sv]
// ----------------------------------------------------------------------------
// Lamp mode controller stream interface
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface lmc_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/core/lmc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// Lamp mode controller configuration registers
// Write-only register file holding debounce, delay and dimmer settings.
// ----------------------------------------------------------------------------
`default_nettype none

module lmc_cfg_regs (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lmc_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [lmc_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  output lmc_pkg::cfg_t                           cfg_o
);

  lmc_pkg::cfg_t cfg_q;
  lmc_pkg::cfg_t cfg_d;

  // Decode the register index; unused indexes are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lmc_pkg::REG_DEBOUNCE_INTERVAL: cfg_d.db.interval = cfg_wdata_i[7:0];
        lmc_pkg::REG_DEBOUNCE_CONFIRM:  cfg_d.db.confirm  = cfg_wdata_i[2:0];
        lmc_pkg::REG_OFF_DELAY:         cfg_d.off_delay   = cfg_wdata_i;
        lmc_pkg::REG_LEVEL_ONE:         cfg_d.level[0]    = cfg_wdata_i;
        lmc_pkg::REG_LEVEL_TWO:         cfg_d.level[1]    = cfg_wdata_i;
        lmc_pkg::REG_LEVEL_THREE:       cfg_d.level[2]    = cfg_wdata_i;
        lmc_pkg::REG_LEVEL_FOUR:        cfg_d.level[3]    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.db.interval <= lmc_pkg::RstInterval;
      cfg_q.db.confirm  <= lmc_pkg::RstConfirm;
      cfg_q.off_delay   <= lmc_pkg::RstOffDelay;
      cfg_q.level[0]    <= lmc_pkg::RstLevelOne;
      cfg_q.level[1]    <= lmc_pkg::RstLevelTwo;
      cfg_q.level[2]    <= lmc_pkg::RstLevelThree;
      cfg_q.level[3]    <= lmc_pkg::RstLevelFour;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/lmc_debouncer.sv]
// ----------------------------------------------------------------------------
// Lamp mode controller button debouncer
// Latches a press edge and qualifies it by periodic samples of the pin.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lamp_mode_controller_unit_assert.svh"

module lmc_debouncer (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire lmc_pkg::db_cfg_t cfg_i,
  input  wire logic     tick_i,
  input  wire logic     run_i,
  input  wire logic     press_i,
  input  wire logic     pin_i,
  output logic          hit_o
);

  logic       pending_q, pending_d;
  logic [2:0] confirm_q, confirm_d;
  logic [7:0] interval_q, interval_d;

  // One qualification step per tick; the press edge is latched even when
  // the debouncer is held off.
  always_comb begin
    pending_d  = pending_q | press_i;
    confirm_d  = confirm_q;
    interval_d = interval_q;
    hit_o      = 1'b0;
    if (run_i && pending_d) begin
      if (confirm_q == 3'd0) begin
        confirm_d  = 3'd1;
        interval_d = 8'd0;
      end else if (interval_q != lmc_pkg::IntervalMax) begin
        interval_d = interval_q + 8'd1;
      end
      if (interval_d >= cfg_i.interval) begin
        interval_d = 8'd0;
        if (!pin_i) begin
          confirm_d = 3'd1;
        end else if (confirm_d >= cfg_i.confirm) begin
          confirm_d = 3'd0;
          pending_d = 1'b0;
          hit_o     = 1'b1;
        end else begin
          confirm_d = confirm_d + 3'd1;
        end
      end
    end
    if (!tick_i) begin
      hit_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q  <= 1'b0;
      confirm_q  <= 3'd0;
      interval_q <= 8'd0;
    end else if (tick_i) begin
      pending_q  <= pending_d;
      confirm_q  <= confirm_d;
      interval_q <= interval_d;
    end
  end

  // An idle debouncer has no qualification in progress.
  `LMC_ASSERT(a_idle_no_confirm, clk_i, rst_ni, !pending_q |-> confirm_q == 3'd0,
              "debouncer counts confirmations without a pending press")
  // The state only moves on a tick.
  `LMC_ASSERT(a_hold_between_ticks, clk_i, rst_ni,
              !tick_i |=> $stable(pending_q) && $stable(confirm_q) && $stable(interval_q),
              "debouncer state changed without a tick")

endmodule

`default_nettype wire

[rtl/core/lamp_mode_controller_unit.sv]
// ----------------------------------------------------------------------------
// Lamp mode controller
// Mode sequencing, lamp, delay timer and dimmer for one tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one millisecond tick and yields exactly one result,
// registered and offered on the output channel on the cycle after the
// transfer. The whole tick update is one pass of logic from the state
// registers into the state and result registers, so a tick is taken on every
// cycle in which the result register is empty or being emptied: one tick per
// clock sustained. Configuration writes are taken on any cycle and must only
// be made with no tick outstanding. No clearing pass is needed after reset.
`default_nettype none

`include "lamp_mode_controller_unit_assert.svh"

module lamp_mode_controller_unit #(
  parameter int unsigned DELAY_WIDTH = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [lmc_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  wire logic [lmc_pkg::CfgDataWidth-1:0]   cfg_wdata_i,
  lmc_stream_if.sink                              in_i,
  lmc_stream_if.source                            out_o
);

  localparam int unsigned CmpWidth = (DELAY_WIDTH > 16) ? DELAY_WIDTH : 16;
  localparam logic [DELAY_WIDTH-1:0] DelayMax = {DELAY_WIDTH{1'b1}};

  lmc_pkg::cfg_t cfg;
  lmc_pkg::in_t  tick;

  lmc_pkg::mode_e         mode_q, mode_d;
  logic                   lamp_q, lamp_d;
  logic [2:0]             step_q, step_d;
  logic [15:0]            pwm_q, pwm_d;
  logic                   dact_q, dact_d;
  logic [DELAY_WIDTH-1:0] dcnt_q, dcnt_d;
  logic [DELAY_WIDTH-1:0] dcnt_inc;

  logic           out_valid_q;
  lmc_pkg::out_t  out_q;

  logic           in_xfer;
  logic           mode_hit, action_hit, action_run;

  assign tick    = in_i.payload;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer = in_i.valid && in_i.ready;

  lmc_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  lmc_debouncer u_mode_db (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg.db),
    .tick_i  (in_xfer),
    .run_i   (1'b1),
    .press_i (tick.mode_press),
    .pin_i   (tick.mode_pin),
    .hit_o   (mode_hit)
  );

  // The action button is only qualified outside ambient mode.
  assign action_run = (mode_hit ? lmc_pkg::mode_e'(mode_q + 2'd1) : mode_q)
                      != lmc_pkg::MODE_AMBIENT;

  lmc_debouncer u_action_db (
    .clk_i,
    .rst_ni,
    .cfg_i   (cfg.db),
    .tick_i  (in_xfer),
    .run_i   (action_run),
    .press_i (tick.action_press),
    .pin_i   (tick.action_pin),
    .hit_o   (action_hit)
  );

  // Tick update: mode change, delay timer, then the behaviour of the mode.
  always_comb begin
    mode_d   = mode_q;
    lamp_d   = lamp_q;
    step_d   = step_q;
    pwm_d    = pwm_q;
    dact_d   = dact_q;
    dcnt_d   = dcnt_q;
    dcnt_inc = dcnt_q;

    if (mode_hit) begin
      mode_d = lmc_pkg::mode_e'(mode_q + 2'd1);
      lamp_d = 1'b0;
      step_d = 3'd0;
      dact_d = 1'b0;
      dcnt_d = '0;
    end

    if (dact_d) begin
      dcnt_inc = (dcnt_d != DelayMax) ? dcnt_d + 1'b1 : dcnt_d;
      if (CmpWidth'(dcnt_inc) >= CmpWidth'(cfg.off_delay) || dcnt_inc == DelayMax) begin
        dact_d = 1'b0;
        dcnt_d = '0;
        lamp_d = 1'b0;
      end else begin
        dcnt_d = dcnt_inc;
      end
    end

    unique case (mode_d)
      lmc_pkg::MODE_AMBIENT: begin
        lamp_d = tick.ambient_sample < tick.reference_sample;
      end
      lmc_pkg::MODE_MANUAL: begin
        if (action_hit) begin
          lamp_d = !lamp_d;
        end
      end
      lmc_pkg::MODE_DELAY: begin
        if (action_hit) begin
          lamp_d = 1'b1;
          if (!dact_d) begin
            dact_d = 1'b1;
            dcnt_d = '0;
          end
        end
      end
      lmc_pkg::MODE_DIMMER: begin
        if (action_hit) begin
          step_d = (step_d >= lmc_pkg::TopStep) ? 3'd0 : step_d + 3'd1;
        end
        if (step_d == 3'd0 || step_d > lmc_pkg::TopStep) begin
          pwm_d = 16'd0;
        end else begin
          pwm_d = cfg.level[2'(step_d - 3'd1)];
        end
      end
      default: ;
    endcase
  end

  // State moves on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= lmc_pkg::MODE_AMBIENT;
      lamp_q <= 1'b0;
      step_q <= 3'd0;
      pwm_q  <= 16'd0;
      dact_q <= 1'b0;
      dcnt_q <= '0;
    end else if (in_xfer) begin
      mode_q <= mode_d;
      lamp_q <= lamp_d;
      step_q <= step_d;
      pwm_q  <= pwm_d;
      dact_q <= dact_d;
      dcnt_q <= dcnt_d;
    end
  end

  // Result register; filled on each input transfer, emptied on output transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_q.lamp_on      <= lamp_d;
      out_q.pwm_compare  <= pwm_d;
      out_q.current_mode <= mode_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  // The dimmer step stays within its five levels.
  `LMC_ASSERT(a_step_range, clk_i, rst_ni, step_q <= lmc_pkg::TopStep,
              "dimmer step beyond the top level")
  // A running delay only exists in delay mode.
  `LMC_ASSERT(a_delay_in_mode, clk_i, rst_ni, dact_q |-> mode_q == lmc_pkg::MODE_DELAY,
              "delay timer running outside delay mode")
  // A running delay keeps the lamp lit.
  `LMC_ASSERT(a_delay_lamp, clk_i, rst_ni, dact_q |-> lamp_q,
              "delay timer running with the lamp off")
  // The mode only changes on an input transfer.
  `LMC_ASSERT(a_mode_on_xfer, clk_i, rst_ni, !in_xfer |=> $stable(mode_q),
              "mode changed without an input transfer")
  // Reset leaves the result register empty.
  `LMC_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |-> !out_valid_q,
                     "result valid during reset")

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Lamp mode controller testbench
// Drives millisecond ticks into the controller and checks every result
// against an in-bench prediction of the mode, lamp, delay and dimmer state.
// ----------------------------------------------------------------------------
// A short directed run covers the ambient comparison extremes and the
// behaviour of each mode. Random ticks then model button presses that are
// held long enough to qualify, short presses that bounce out, and stray
// edges. Register settings change between phases while no tick is
// outstanding. Both channels stall at random, apart from one long stretch.

module tb_top;

  localparam int unsigned DelayWidth = 16;
  localparam int unsigned DelayMax   = (1 << DelayWidth) - 1;
  localparam int unsigned StallLimit = 4000;

  // One button's press qualification state.
  typedef struct {
    logic       pending;
    logic [2:0] confirm;
    logic [7:0] interval;
  } qualifier_t;

  // Predicts the controller result for each accepted tick and compares the
  // results in order of arrival.
  class lamp_checker;
    logic [7:0]  interval_cfg;
    logic [2:0]  confirm_cfg;
    logic [15:0] off_delay_cfg;
    logic [15:0] level_cfg [lmc_pkg::NumLevels];

    lmc_pkg::mode_e mode;
    logic        lamp;
    logic [2:0]  step;
    logic [15:0] pwm;
    logic        delay_on;
    int unsigned delay_cnt;
    qualifier_t  mode_q;
    qualifier_t  action_q;

    lmc_pkg::out_t expected_outputs [$];
    int unsigned errors, ticks, results, mode_steps, action_hits, delay_expiries;

    function new();
      interval_cfg  = lmc_pkg::RstInterval;
      confirm_cfg   = lmc_pkg::RstConfirm;
      off_delay_cfg = lmc_pkg::RstOffDelay;
      level_cfg[0]  = lmc_pkg::RstLevelOne;
      level_cfg[1]  = lmc_pkg::RstLevelTwo;
      level_cfg[2]  = lmc_pkg::RstLevelThree;
      level_cfg[3]  = lmc_pkg::RstLevelFour;
      mode      = lmc_pkg::MODE_AMBIENT;
      lamp      = 1'b0;
      step      = 3'd0;
      pwm       = 16'd0;
      delay_on  = 1'b0;
      delay_cnt = 0;
      mode_q    = '{1'b0, 3'd0, 8'd0};
      action_q  = '{1'b0, 3'd0, 8'd0};
    endfunction

    function void write_reg(lmc_pkg::reg_idx_e idx, logic [15:0] value);
      case (idx)
        lmc_pkg::REG_DEBOUNCE_INTERVAL: interval_cfg  = value[7:0];
        lmc_pkg::REG_DEBOUNCE_CONFIRM:  confirm_cfg   = value[2:0];
        lmc_pkg::REG_OFF_DELAY:         off_delay_cfg = value;
        lmc_pkg::REG_LEVEL_ONE:         level_cfg[0]  = value;
        lmc_pkg::REG_LEVEL_TWO:         level_cfg[1]  = value;
        lmc_pkg::REG_LEVEL_THREE:       level_cfg[2]  = value;
        lmc_pkg::REG_LEVEL_FOUR:        level_cfg[3]  = value;
        default: ;
      endcase
    endfunction

    // Advances one qualifier by a tick; returns 1 when the press is accepted.
    function logic qualify(inout qualifier_t q, input logic pin);
      if (!q.pending) return 1'b0;
      if (q.confirm == 3'd0) begin
        q.confirm  = 3'd1;
        q.interval = 8'd0;
      end else if (q.interval < lmc_pkg::IntervalMax) begin
        q.interval = q.interval + 8'd1;
      end
      if (q.interval >= interval_cfg) begin
        q.interval = 8'd0;
        if (!pin) begin
          q.confirm = 3'd1;
        end else if (q.confirm >= confirm_cfg) begin
          q.confirm = 3'd0;
          q.pending = 1'b0;
          return 1'b1;
        end else begin
          q.confirm = q.confirm + 3'd1;
        end
      end
      return 1'b0;
    endfunction

    // Notes an accepted tick and queues the result it must produce.
    function void take_tick(lmc_pkg::in_t t);
      logic hit;
      lmc_pkg::out_t want;
      ticks++;
      if (t.mode_press) mode_q.pending = 1'b1;
      if (t.action_press) action_q.pending = 1'b1;

      // A qualified mode press steps the mode and cancels everything running.
      if (qualify(mode_q, t.mode_pin)) begin
        mode      = (mode == lmc_pkg::MODE_DIMMER) ? lmc_pkg::MODE_AMBIENT
                                                   : lmc_pkg::mode_e'(mode + 2'd1);
        lamp      = 1'b0;
        step      = 3'd0;
        delay_on  = 1'b0;
        delay_cnt = 0;
        mode_steps++;
      end

      // Delay timer, saturating at the width of the counter.
      if (delay_on) begin
        if (delay_cnt < DelayMax) delay_cnt++;
        if (delay_cnt >= off_delay_cfg || delay_cnt >= DelayMax) begin
          delay_on  = 1'b0;
          delay_cnt = 0;
          lamp      = 1'b0;
          delay_expiries++;
        end
      end

      // The action qualifier is frozen while in ambient mode.
      hit = 1'b0;
      if (mode != lmc_pkg::MODE_AMBIENT) hit = qualify(action_q, t.action_pin);
      if (hit) action_hits++;

      case (mode)
        lmc_pkg::MODE_AMBIENT: begin
          lamp = (t.ambient_sample < t.reference_sample);
        end
        lmc_pkg::MODE_MANUAL: begin
          if (hit) lamp = ~lamp;
        end
        lmc_pkg::MODE_DELAY: begin
          if (hit) begin
            lamp = 1'b1;
            if (!delay_on) begin
              delay_on  = 1'b1;
              delay_cnt = 0;
            end
          end
        end
        default: begin
          if (hit) step = (step >= lmc_pkg::TopStep) ? 3'd0 : step + 3'd1;
          pwm = (step == 3'd0 || step > lmc_pkg::TopStep) ? 16'd0
                                                          : level_cfg[2'(step - 3'd1)];
        end
      endcase

      want.lamp_on      = lamp;
      want.pwm_compare  = pwm;
      want.current_mode = mode;
      expected_outputs.push_back(want);
    endfunction

    // Compares one accepted result with the oldest outstanding prediction.
    function void check_output(lmc_pkg::out_t got);
      lmc_pkg::out_t want;
      results++;
      if (expected_outputs.size() == 0) begin
        $display("%0t: result with no tick outstanding: lamp %0b pwm %0d mode %0d",
                 $time, got.lamp_on, got.pwm_compare, got.current_mode);
        errors++;
        return;
      end
      want = expected_outputs.pop_front();
      if (got.lamp_on !== want.lamp_on) begin
        $display("%0t: lamp_on expected %0b, actual %0b", $time, want.lamp_on, got.lamp_on);
        errors++;
      end
      if (got.pwm_compare !== want.pwm_compare) begin
        $display("%0t: pwm_compare expected %0d, actual %0d",
                 $time, want.pwm_compare, got.pwm_compare);
        errors++;
      end
      if (got.current_mode !== want.current_mode) begin
        $display("%0t: current_mode expected %0d, actual %0d",
                 $time, want.current_mode, got.current_mode);
        errors++;
      end
    endfunction
  endclass

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [lmc_pkg::CfgIdxWidth-1:0]  cfg_idx_i;
  logic [lmc_pkg::CfgDataWidth-1:0] cfg_wdata_i;
  logic                             sink_ready = 1'b0;
  logic                             quiet = 1'b0;
  int unsigned                      stall_cycles = 0;
  int                               mode_hold = 0;
  int                               action_hold = 0;
  lamp_checker                      board;

  lmc_stream_if #(.payload_t(lmc_pkg::in_t))  in_if ();
  lmc_stream_if #(.payload_t(lmc_pkg::out_t)) out_if ();

  assign out_if.ready = sink_ready;

  lamp_mode_controller_unit #(.DELAY_WIDTH(DelayWidth)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #1 clk_i = ~clk_i;

  // The result side stalls at random unless a quiet stretch is running.
  always @(posedge clk_i) begin
    sink_ready <= quiet || ($urandom_range(0, 99) >= 8);
  end

  // Transfer monitor and watchdog.
  always @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) board.take_tick(in_if.payload);
    if (out_if.valid && out_if.ready) board.check_output(out_if.payload);
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic lmc_pkg::in_t make_tick(logic mp, logic mpin, logic ap, logic apin,
                                             logic [7:0] amb, logic [7:0] refl);
    lmc_pkg::in_t t;
    t.mode_press       = mp;
    t.mode_pin         = mpin;
    t.action_press     = ap;
    t.action_pin       = apin;
    t.ambient_sample   = amb;
    t.reference_sample = refl;
    return t;
  endfunction

  // Offers one tick, with an occasional idle gap first, and waits for the
  // transfer. Valid is left high for a following tick.
  task automatic send_tick(lmc_pkg::in_t t);
    while (!quiet && $urandom_range(0, 99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.payload <= t;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Stops offering ticks and waits until every result has come back. The
  // first edge lets the monitor note the last transfer before the count is read.
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (board.expected_outputs.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apply_settings(logic [7:0] ivl, logic [2:0] conf, logic [15:0] dly,
                                logic [15:0] l1, logic [15:0] l2,
                                logic [15:0] l3, logic [15:0] l4);
    logic [15:0]       vals [7];
    lmc_pkg::reg_idx_e idx;
    vals = '{16'(ivl), 16'(conf), dly, l1, l2, l3, l4};
    for (int i = 0; i < 7; i++) begin
      idx = lmc_pkg::reg_idx_e'(i);
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx;
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
      board.write_reg(idx, vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  // One button's activity for a tick: mostly presses held long enough to
  // qualify under the current settings, some too short, bounce and stray edges.
  function automatic void button_activity(inout int hold, input int start_permille,
                                          output logic rise, output logic pin);
    int need;
    need = (int'(board.interval_cfg) + 1) * (int'(board.confirm_cfg) + 1) + 2;
    if (hold > 0) begin
      hold--;
      pin  = ($urandom_range(0, 99) >= 4);
      rise = ($urandom_range(0, 99) < 2);
    end else if ($urandom_range(0, 999) < start_permille) begin
      hold = $urandom_range(need / 2 + 1, need * 2);
      rise = 1'b1;
      pin  = 1'b1;
    end else begin
      pin  = ($urandom_range(0, 99) < 5);
      rise = ($urandom_range(0, 199) == 0);
    end
  endfunction

  task automatic random_ticks(int n);
    lmc_pkg::in_t t;
    for (int i = 0; i < n; i++) begin
      button_activity(mode_hold, 20, t.mode_press, t.mode_pin);
      button_activity(action_hold, 120, t.action_press, t.action_pin);
      t.ambient_sample   = 8'($urandom_range(0, 255));
      t.reference_sample = ($urandom_range(0, 9) == 0) ? t.ambient_sample
                                                       : 8'($urandom_range(0, 255));
      send_tick(t);
    end
  endtask

  task automatic run_phase(logic [7:0] ivl, logic [2:0] conf, logic [15:0] dly,
                           logic [15:0] l1, logic [15:0] l2,
                           logic [15:0] l3, logic [15:0] l4, int n);
    apply_settings(ivl, conf, dly, l1, l2, l3, l4);
    random_ticks(n);
    settle();
  endtask

  initial begin
    board = new();
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= lmc_pkg::REG_DEBOUNCE_INTERVAL;
    cfg_wdata_i   <= '0;
    in_if.valid   <= 1'b0;
    in_if.payload <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Ambient comparison at the sample extremes, under the reset settings.
    // The first tick latches an action press that must wait out ambient mode.
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'd0, 8'd255));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd128, 8'd128));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd255));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'd254, 8'd255));
    random_ticks(100);
    settle();

    // Zero interval and zero confirm: a press with the pin high qualifies at
    // once, so every mode can be walked through in a few ticks.
    apply_settings(8'd0, 3'd0, 16'd3, 16'd0, 16'hFFFF, 16'h5555, 16'hAAAA);
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b0, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 1'b0, 8'h5A, 8'hA5));
    // Mode steps to delay and the action fires on the same tick.
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h5A, 8'hA5));
    repeat (3) send_tick(make_tick(1'b0, 1'b0, 1'b0, 1'b0, 8'h5A, 8'hA5));
    // Dimmer: five steps wrap the level back to zero.
    send_tick(make_tick(1'b1, 1'b1, 1'b0, 1'b0, 8'h5A, 8'hA5));
    repeat (5) send_tick(make_tick(1'b0, 1'b0, 1'b1, 1'b1, 8'h5A, 8'hA5));
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 1'b1, 8'h5A, 8'hA5));
    random_ticks(150);
    settle();

    run_phase(8'd1, 3'd1, 16'd1, 16'hFFFF, 16'd0, 16'd1, 16'h8000, 200);
    run_phase(8'd2, 3'd7, 16'd20, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 250);
    // A zero off delay ends the delay on the tick after the trigger.
    run_phase(8'd0, 3'd7, 16'd0, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 150);
    run_phase(8'd255, 3'd1, 16'hFFFF, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 300);
    // A long stretch with neither side stalling.
    quiet = 1'b1;
    run_phase(8'd3, 3'd2, 16'd50, 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 250);
    quiet = 1'b0;

    $display("Covered %0d ticks over seven register settings: %0d mode steps, %0d accepted",
             board.ticks, board.mode_steps, board.action_hits);
    $display("action presses and %0d delay expiries; %0d results checked, %0d mismatches.",
             board.delay_expiries, board.results, board.errors);
    if (board.errors == 0 && board.expected_outputs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lmc_pkg.sv
rtl/core/lmc_stream_if.sv
rtl/core/lmc_cfg_regs.sv
rtl/core/lmc_debouncer.sv
rtl/core/lamp_mode_controller_unit.sv
bench/tb_top.sv
